>>> hdl/prad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prad_pkg: shared types and codes of the priority region address decoder
// Request and response layouts, the token that walks the cell chain, and the
// mode and status codes.
// ----------------------------------------------------------------------------
package prad_pkg;

    // Field widths of the request and response
    localparam int unsigned ENTRY_W  = 4;
    localparam int unsigned START_W  = 39;
    localparam int unsigned SIZE_W   = 40;
    localparam int unsigned RANK_W   = 8;
    localparam int unsigned LOOKUP_W = 39;
    localparam int unsigned TARGET_W = 4;

    // Request modes
    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // Response status codes
    localparam logic STATUS_MAPPED   = 1'b0;
    localparam logic STATUS_UNMAPPED = 1'b1;

    typedef struct packed {
        logic                mode;
        logic [ENTRY_W-1:0]  entry_index;
        logic                entry_enable;
        logic [START_W-1:0]  region_start;
        logic [SIZE_W-1:0]   region_size;
        logic [RANK_W-1:0]   region_rank;
        logic [LOOKUP_W-1:0] lookup_address;
    } req_t;

    typedef struct packed {
        logic                status;
        logic [TARGET_W-1:0] target_index;
    } rsp_t;

    // Token handed from cell to cell: the request plus the best match so far
    typedef struct packed {
        logic                vld;
        req_t                req;
        logic                found;
        logic [TARGET_W-1:0] best;
    } tok_t;

endpackage

>>> hdl/prad_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prad_stream_if: valid/ready channel
// Carries one request or response per handshake; the payload type is set
// per instance.
// ----------------------------------------------------------------------------
interface prad_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

>>> hdl/prad_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prad_cell: one region slot of the decoder chain
// Holds one region (valid, base, length, priority). A write request that
// names this slot loads it as it passes; a lookup request is range checked
// here and picks up this slot if it beats the best match so far.
// ----------------------------------------------------------------------------
module prad_cell #(
    parameter int unsigned CELL_INDEX    = 0,
    parameter int unsigned ADDR_BITS     = 39,
    parameter int unsigned PRIORITY_BITS = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  prad_pkg::tok_t           tok_in,
    input  logic [PRIORITY_BITS-1:0] prio_in,
    output prad_pkg::tok_t           tok_out,
    output logic [PRIORITY_BITS-1:0] prio_out
);
    import prad_pkg::*;

    localparam int unsigned LEN_W = ADDR_BITS + 1;

    logic                     slot_valid_reg;
    logic [ADDR_BITS-1:0]     slot_base_reg;
    logic [LEN_W-1:0]         slot_length_reg;
    logic [PRIORITY_BITS-1:0] slot_rank_reg;

    tok_t                     tok_reg;
    tok_t                     tok_next;
    logic [PRIORITY_BITS-1:0] best_prio_reg;
    logic [PRIORITY_BITS-1:0] best_prio_next;

    logic                     is_write;
    logic                     is_lookup;
    logic                     slot_sel;
    logic                     slot_wr;
    logic [ADDR_BITS-1:0]     addr;
    logic [ADDR_BITS-1:0]     offset;
    logic                     hit;
    logic                     take;

    // Decode the passing request
    assign is_write  = tok_in.vld && (tok_in.req.mode == MODE_WRITE);
    assign is_lookup = tok_in.vld && (tok_in.req.mode == MODE_LOOKUP);
    assign slot_sel  = (32'(tok_in.req.entry_index) == CELL_INDEX);
    assign slot_wr   = advance && is_write && slot_sel;

    // Range check: base <= addr and addr - base < length
    assign addr   = ADDR_BITS'(tok_in.req.lookup_address);
    assign offset = addr - slot_base_reg;
    assign hit    = slot_valid_reg && (addr >= slot_base_reg)
                    && (LEN_W'(offset) < slot_length_reg);

    // Strictly higher priority wins; ties keep the lower slot seen earlier
    assign take = is_lookup && hit && (!tok_in.found || (slot_rank_reg > prio_in));

    // Update the best match carried by the token
    always_comb
    begin
        tok_next       = tok_in;
        best_prio_next = prio_in;
        if (take)
        begin
            tok_next.found = 1'b1;
            tok_next.best  = TARGET_W'(CELL_INDEX);
            best_prio_next = slot_rank_reg;
        end
    end

    // Hold the slot valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
        end
        else if (slot_wr)
        begin
            slot_valid_reg <= tok_in.req.entry_enable;
        end
    end

    // Load the slot contents
    always_ff @(posedge clk)
    begin
        if (slot_wr)
        begin
            slot_base_reg   <= ADDR_BITS'(tok_in.req.region_start);
            slot_length_reg <= LEN_W'(tok_in.req.region_size);
            slot_rank_reg   <= PRIORITY_BITS'(tok_in.req.region_rank);
        end
    end

    // Advance the token to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (advance)
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            best_prio_reg <= best_prio_next;
        end
    end

    assign tok_out  = tok_reg;
    assign prio_out = best_prio_reg;

    // A match found upstream is never lost in this cell
    a_found_kept: assert property (@(posedge clk) disable iff (!rst_n)
        advance && tok_in.vld && tok_in.found |=> tok_reg.found)
        else $error("prad_cell: best match dropped");

    // The carried priority never falls while a match is held
    a_prio_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        advance && tok_in.vld && tok_in.found |=> best_prio_reg >= $past(prio_in))
        else $error("prad_cell: best priority decreased");

    // An enabling write to this slot makes it valid
    a_slot_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        slot_wr && tok_in.req.entry_enable |=> slot_valid_reg)
        else $error("prad_cell: slot not loaded");

endmodule

>>> hdl/priority_region_address_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_region_address_decoder: bus address decoder with region priority
// A chain of region cells. Write requests load one slot as they pass; lookup
// requests collect the highest priority matching slot and leave one response.
// ----------------------------------------------------------------------------
//  channel  dir  payload  per request
//  req      in   req_t    write: none, lookup: one response
//  rsp      out  rsp_t    status and target slot
//
//  One request enters per cycle while the chain advances; a request passes
//  the NUM_REGIONS cells in order, one cell per advancing cycle.
//  Requests stay in order, so a lookup always sees every earlier write.
//  A response not taken stalls the whole chain; req.ready follows it.
//  Reset clears all slot valid bits and empties the chain.
// ----------------------------------------------------------------------------
module priority_region_address_decoder #(
    parameter int unsigned NUM_REGIONS   = 16,
    parameter int unsigned ADDR_BITS     = 39,
    parameter int unsigned PRIORITY_BITS = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    prad_stream_if.sink    req,
    prad_stream_if.source  rsp
);
    import prad_pkg::*;

    tok_t                     chain_tok  [NUM_REGIONS+1];
    logic [PRIORITY_BITS-1:0] chain_prio [NUM_REGIONS+1];
    tok_t                     tail;
    rsp_t                     rsp_data;
    logic                     rsp_vld;
    logic                     advance;

    // Feed the head of the chain
    always_comb
    begin
        chain_tok[0].vld   = req.valid;
        chain_tok[0].req   = req.payload;
        chain_tok[0].found = 1'b0;
        chain_tok[0].best  = '0;
        chain_prio[0]      = '0;
    end

    // Row of region cells
    for (genvar i = 0; i < NUM_REGIONS; i++)
    begin : g_cell
        prad_cell #(
            .CELL_INDEX    (i),
            .ADDR_BITS     (ADDR_BITS),
            .PRIORITY_BITS (PRIORITY_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .tok_in   (chain_tok[i]),
            .prio_in  (chain_prio[i]),
            .tok_out  (chain_tok[i+1]),
            .prio_out (chain_prio[i+1])
        );
    end

    // Turn the chain tail into a response; writes drop out here
    assign tail    = chain_tok[NUM_REGIONS];
    assign rsp_vld = tail.vld && (tail.req.mode == MODE_LOOKUP);

    always_comb
    begin
        rsp_data.status       = tail.found ? STATUS_MAPPED : STATUS_UNMAPPED;
        rsp_data.target_index = tail.best;
    end

    // Move the chain unless a response waits
    assign advance     = !rsp_vld || rsp.ready;
    assign req.ready   = advance;
    assign rsp.valid   = rsp_vld;
    assign rsp.payload = rsp_data;

    // An unmapped response names slot zero
    a_unmapped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_vld && (rsp_data.status == STATUS_UNMAPPED) |-> (rsp_data.target_index == '0))
        else $error("decoder: unmapped response with nonzero target");

    // A stalled chain holds its tail
    a_tail_held: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(tail))
        else $error("decoder: chain moved while stalled");

endmodule

>>> test/priority_region_address_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_region_address_decoder_tb: self-checking bench for the decoder
// Drives region writes and address lookups through the request channel,
// keeps its own copy of the region table to predict every decode, and checks
// each response in order. Both channels idle at random, with a stretch of
// back-to-back traffic and pauses until every pending lookup has been answered.
// ----------------------------------------------------------------------------
module priority_region_address_decoder_tb;

    import prad_pkg::*;

    localparam int REGION_COUNT  = 16;
    localparam int DRAIN_CYCLES  = 48;
    localparam int PRINT_LIMIT   = 100;
    localparam int IDLE_PCT      = 34;

    localparam logic [START_W-1:0] ADDR_TOP = {START_W{1'b1}};
    localparam logic [SIZE_W-1:0]  SIZE_MAX = {1'b1, {(SIZE_W-1){1'b0}}};

    logic clk;
    logic rst_n;

    prad_stream_if #(.payload_t(req_t)) req_if ();
    prad_stream_if #(.payload_t(rsp_t)) rsp_if ();

    priority_region_address_decoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Mirror of the region table
    logic               region_valid  [REGION_COUNT];
    logic [START_W-1:0] region_base   [REGION_COUNT];
    logic [SIZE_W-1:0]  region_length [REGION_COUNT];
    logic [RANK_W-1:0]  region_rank_q [REGION_COUNT];

    rsp_t pending_decodes [$];
    int   error_count;
    int   req_idle_pct;
    int   rsp_idle_pct;
    logic [START_W-1:0] cluster_base;

    // Clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Watchdog
    initial
    begin
        #3_000_000;
        $display("priority_region_address_decoder_tb: errors");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("%0t ns: %s", $time, msg);
    endtask

    // Predict the decode of one address against the mirrored table
    function automatic rsp_t decode_address(input logic [START_W-1:0] addr);
        rsp_t              r;
        logic              found;
        logic [RANK_W-1:0] best_rank;
        logic [SIZE_W-1:0] span;
        r.status       = STATUS_UNMAPPED;
        r.target_index = '0;
        found          = 1'b0;
        best_rank      = '0;
        for (int k = 0; k < REGION_COUNT; k++)
        begin
            span = {1'b0, addr} - {1'b0, region_base[k]};
            if (region_valid[k] && addr >= region_base[k] && span < region_length[k]
                && (!found || region_rank_q[k] > best_rank))
            begin
                found          = 1'b1;
                best_rank      = region_rank_q[k];
                r.status       = STATUS_MAPPED;
                r.target_index = TARGET_W'(k);
            end
        end
        return r;
    endfunction

    function automatic logic [START_W-1:0] rand_addr();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[START_W-1:0];
    endfunction

    function automatic logic [SIZE_W-1:0] rand_size();
        logic [63:0] w;
        w = {$urandom, $urandom};
        if (w[SIZE_W-1:0] > SIZE_MAX)
            return w[SIZE_W-1:0] & (SIZE_MAX - 1'b1);
        return w[SIZE_W-1:0];
    endfunction

    // Fully random request within the legal field ranges
    function automatic req_t random_request();
        req_t r;
        r.mode           = logic'($urandom_range(0, 1));
        r.entry_index    = ENTRY_W'($urandom_range(0, REGION_COUNT - 1));
        r.entry_enable   = logic'($urandom_range(0, 1));
        r.region_start   = rand_addr();
        r.region_size    = rand_size();
        r.region_rank    = RANK_W'($urandom_range(0, 255));
        r.lookup_address = rand_addr();
        return r;
    endfunction

    // Send one request, then update the mirror or queue the predicted decode
    task automatic send_request(input req_t item);
        @(negedge clk);
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= item;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        if (item.mode == MODE_LOOKUP)
            pending_decodes.push_back(decode_address(item.lookup_address));
        else
        begin
            region_valid[item.entry_index]  = item.entry_enable;
            region_base[item.entry_index]   = item.region_start;
            region_length[item.entry_index] = item.region_size;
            region_rank_q[item.entry_index] = item.region_rank;
        end
    endtask

    task automatic write_region(input int idx, input logic en,
                                input logic [START_W-1:0] base,
                                input logic [SIZE_W-1:0] size,
                                input logic [RANK_W-1:0] rank);
        req_t r;
        r              = random_request();
        r.mode         = MODE_WRITE;
        r.entry_index  = ENTRY_W'(idx);
        r.entry_enable = en;
        r.region_start = base;
        r.region_size  = size;
        r.region_rank  = rank;
        send_request(r);
    endtask

    task automatic lookup(input logic [START_W-1:0] addr);
        req_t r;
        r                = random_request();
        r.mode           = MODE_LOOKUP;
        r.lookup_address = addr;
        send_request(r);
    endtask

    // Drop valid and hold until every predicted response has come back
    task automatic wait_drained();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (pending_decodes.size() != 0)
            @(posedge clk);
    endtask

    // Extremes, empty table, zero length, top of space, ties and disables
    task automatic test_directed();
        lookup('0);
        lookup(ADDR_TOP);
        write_region(0, 1'b1, '0, SIZE_MAX, 8'd0);
        lookup('0);
        lookup(ADDR_TOP);
        write_region(1, 1'b1, 39'h100, '0, 8'd255);
        lookup(39'h100);
        write_region(2, 1'b1, ADDR_TOP - 39'd15, SIZE_MAX, 8'd10);
        lookup(ADDR_TOP);
        lookup(ADDR_TOP - 39'd16);
        write_region(3, 1'b1, ADDR_TOP - 39'd15, 40'd16, 8'd10);
        lookup(ADDR_TOP - 39'd15);
        write_region(15, 1'b1, 39'h1000, 40'h10, 8'd255);
        lookup(39'h1000);
        lookup(39'h100F);
        lookup(39'h1010);
        write_region(15, 1'b0, 39'h1000, 40'h10, 8'd255);
        lookup(39'h1000);
        write_region(0, 1'b0, '0, SIZE_MAX, 8'd0);
        lookup(39'h5);
        write_region(14, 1'b1, 39'h55_5555_5555, 40'd1, 8'h55);
        lookup(39'h55_5555_5555);
        lookup(39'h55_5555_5556);
    endtask

    // Mostly clustered writes and lookups aimed at written regions, plus noise
    task automatic test_random_traffic(input int count);
        req_t              r;
        int                pick;
        int                sel;
        int                k;
        logic [START_W-1:0] ofs;
        for (int i = 0; i < count; i++)
        begin
            if (i % 200 == 0)
                cluster_base = ($urandom_range(0, 3) == 0) ? ADDR_TOP - 39'd2047 : rand_addr();
            r    = random_request();
            pick = $urandom_range(0, 99);
            if (pick >= 10 && pick < 45)
            begin
                r.mode         = MODE_WRITE;
                r.entry_enable = ($urandom_range(0, 99) < 85);
                sel = $urandom_range(0, 99);
                if (sel < 60)
                    r.region_start = cluster_base + START_W'($urandom_range(0, 255));
                else if (sel < 80)
                    r.region_start = ADDR_TOP - START_W'($urandom_range(0, 511));
                sel = $urandom_range(0, 99);
                if (sel < 10)
                    r.region_size = '0;
                else if (sel < 20)
                    r.region_size = SIZE_MAX;
                else if (sel >= 30)
                    r.region_size = SIZE_W'($urandom_range(1, 600));
                if ($urandom_range(0, 99) < 40)
                    r.region_rank = RANK_W'($urandom_range(0, 3));
            end
            else if (pick >= 45)
            begin
                r.mode = MODE_LOOKUP;
                sel = $urandom_range(0, 99);
                if (sel < 60)
                begin
                    k   = $urandom_range(0, REGION_COUNT - 1);
                    ofs = START_W'($urandom_range(0, 700));
                    r.lookup_address = region_base[k] + ofs - START_W'(8);
                end
                else if (sel < 75)
                    r.lookup_address = cluster_base + START_W'($urandom_range(0, 1023));
                else if (sel < 85)
                    r.lookup_address = ADDR_TOP - START_W'($urandom_range(0, 600));
            end
            send_request(r);
        end
    endtask

    // Long stretch with no idling on either side
    task automatic test_back_to_back(input int count);
        req_idle_pct = 0;
        rsp_idle_pct = 0;
        test_random_traffic(count);
        req_idle_pct = IDLE_PCT;
        rsp_idle_pct = IDLE_PCT;
    endtask

    // Bursts separated by a wait until every pending lookup has been answered
    task automatic test_drain_pause();
        for (int n = 0; n < 4; n++)
        begin
            test_random_traffic(40);
            wait_drained();
        end
    endtask

    // Response checker
    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_decodes.size() == 0)
                report_mismatch($sformatf("response with no lookup pending: status %0b target %0d",
                                          rsp_if.payload.status, rsp_if.payload.target_index));
            else
            begin
                exp_rsp = pending_decodes.pop_front();
                if (rsp_if.payload.status !== exp_rsp.status)
                    report_mismatch($sformatf("status got %0b want %0b",
                                              rsp_if.payload.status, exp_rsp.status));
                if (rsp_if.payload.target_index !== exp_rsp.target_index)
                    report_mismatch($sformatf("target_index got %0d want %0d",
                                              rsp_if.payload.target_index,
                                              exp_rsp.target_index));
            end
        end
    end

    // Response back-pressure
    always @(negedge clk)
    begin
        rsp_if.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
    end

    initial
    begin
        error_count    = 0;
        req_idle_pct   = IDLE_PCT;
        rsp_idle_pct   = IDLE_PCT;
        cluster_base   = '0;
        rst_n          = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
        for (int k = 0; k < REGION_COUNT; k++)
        begin
            region_valid[k]  = 1'b0;
            region_base[k]   = '0;
            region_length[k] = '0;
            region_rank_q[k] = '0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_traffic(500);
        test_back_to_back(350);
        test_drain_pause();
        test_random_traffic(420);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("priority_region_address_decoder_tb: clean");
        else
            $display("priority_region_address_decoder_tb: errors");
        $finish;
    end

endmodule

>>> priority_region_address_decoder.f
hdl/prad_pkg.sv
hdl/prad_stream_if.sv
hdl/prad_cell.sv
hdl/priority_region_address_decoder.sv
test/priority_region_address_decoder_tb.sv
